### rtl/vpfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpfc_pkg
// Types and constants of the vertex position format converter.
// ----------------------------------------------------------------------------
package vpfc_pkg;

  localparam logic [2:0] FMT_U8  = 3'd0;
  localparam logic [2:0] FMT_S8  = 3'd1;
  localparam logic [2:0] FMT_U16 = 3'd2;
  localparam logic [2:0] FMT_S16 = 3'd3;

  localparam logic [1:0] REG_SOURCE_FORMAT   = 2'd0;
  localparam logic [1:0] REG_COMPONENT_COUNT = 2'd1;
  localparam logic [1:0] REG_FRAC_BITS       = 2'd2;
  localparam logic [1:0] REG_FLOAT_OUTPUT    = 2'd3;

  localparam logic [1:0] COUNT_THREE = 2'd3;

  typedef struct packed {
    logic [31:0] comp_x;
    logic [31:0] comp_y;
    logic [31:0] comp_z;
  } in_t;

  typedef struct packed {
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [5:0]  scale_word;
    logic        scale_valid;
  } out_t;

  typedef struct packed {
    logic [2:0] source_format;
    logic       has_z;
    logic [4:0] frac_bits;
    logic       float_output;
  } cfg_t;

endpackage

### rtl/vpfc_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpfc_conv
// One component: extend per format, optionally convert to scaled float32; other formats pass the raw word through.
// ----------------------------------------------------------------------------
module vpfc_conv (
  input  vpfc_pkg::cfg_t cfg_i,
  input  logic           present_i,
  input  logic [31:0]    raw_i,
  output logic [31:0]    word_o
);

  logic [16:0] ext;      // 17-bit signed value
  logic        neg;
  logic [15:0] mag;
  logic [3:0]  msb;
  logic [15:0] norm;
  logic [8:0]  expo;
  logic [31:0] flt;

  always_comb begin
    case (cfg_i.source_format)
      vpfc_pkg::FMT_U8:  ext = {9'd0, raw_i[7:0]};
      vpfc_pkg::FMT_S8:  ext = {{9{raw_i[7]}}, raw_i[7:0]};
      vpfc_pkg::FMT_U16: ext = {1'b0, raw_i[15:0]};
      default:           ext = {raw_i[15], raw_i[15:0]};
    endcase
    if (!present_i) ext = '0;
    neg = ext[16];
    mag = neg ? 16'(-ext) : ext[15:0];
    // -32768 gives mag 0x8000, still correct
    msb = '0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) msb = 4'(i);
    end
    norm = mag << (4'd15 - msb);
    expo = 9'd127 + {5'd0, msb} - {4'd0, cfg_i.frac_bits};
    if (mag == '0) flt = '0;
    else flt = {neg, expo[7:0], norm[14:0], 8'd0};

    if (cfg_i.source_format > vpfc_pkg::FMT_S16) word_o = present_i ? raw_i : '0;
    else if (cfg_i.float_output) word_o = flt;
    else word_o = {{15{ext[16]}}, ext};
  end

endmodule

### rtl/vertex_position_format_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_position_format_converter
// Converts a raw 2/3-component vertex position to three 32-bit words.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in      | input     | in_valid/in_ready  | vpfc_pkg::in_t
//  out     | output    | out_valid/out_ready| vpfc_pkg::out_t
//  cfg     | input     | cfg_we (no wait)   | cfg_idx_i, cfg_data_i
//
//  One request per cycle unless stalled: input register, conversion logic,
//  result register.
//  Input stage advances whenever the result register is empty or being taken.
//  Reset clears valid flags and loads register defaults (count 3).
// ----------------------------------------------------------------------------
module vertex_position_format_converter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vpfc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vpfc_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [4:0]     cfg_data_i
);

  logic [2:0] fmt_q;
  logic [1:0] cnt_q;
  logic [4:0] frac_q;
  logic       flt_q;
  vpfc_pkg::cfg_t cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= vpfc_pkg::FMT_U8;
      cnt_q <= vpfc_pkg::COUNT_THREE;
      frac_q <= '0;
      flt_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vpfc_pkg::REG_SOURCE_FORMAT:   fmt_q  <= cfg_data_i[2:0];
        vpfc_pkg::REG_COMPONENT_COUNT: cnt_q  <= cfg_data_i[1:0];
        vpfc_pkg::REG_FRAC_BITS:       frac_q <= cfg_data_i;
        default:                       flt_q  <= cfg_data_i[0];
      endcase
    end
  end

  assign cfg = '{source_format: fmt_q, has_z: (cnt_q == vpfc_pkg::COUNT_THREE),
                 frac_bits: frac_q, float_output: flt_q};

  // input register stage
  logic          s1_valid_q;
  vpfc_pkg::in_t s1_q;
  logic          s1_adv;
  logic          out_free;

  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (in_ready_o) s1_valid_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) s1_q <= in_data_i;
  end

  vpfc_pkg::out_t res;
  logic           scaled;

  vpfc_conv u_cx (.cfg_i(cfg), .present_i(1'b1), .raw_i(s1_q.comp_x), .word_o(res.out_x));
  vpfc_conv u_cy (.cfg_i(cfg), .present_i(1'b1), .raw_i(s1_q.comp_y), .word_o(res.out_y));
  vpfc_conv u_cz (.cfg_i(cfg), .present_i(cfg.has_z), .raw_i(s1_q.comp_z),
                  .word_o(res.out_z));

  assign scaled          = (fmt_q <= vpfc_pkg::FMT_S16) && !flt_q;
  assign res.scale_word  = scaled ? ({1'b0, frac_q} + 6'd1) : 6'd0;
  assign res.scale_valid = scaled;

  // result register
  logic out_valid_q;
  vpfc_pkg::out_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_free) out_valid_q <= s1_valid_q;
  end
  always_ff @(posedge clk_i) begin
    if (s1_adv) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/vpfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpfc_checker
// Port-level checks of the vertex position format converter.
// ----------------------------------------------------------------------------
module vpfc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input vpfc_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_scale_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.scale_valid |-> out_data_o.scale_word == 6'd0)
    else $error("scale word without flag");

  a_scale_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.scale_valid |-> out_data_o.scale_word != 6'd0)
    else $error("scale word zero");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind vertex_position_format_converter vpfc_checker u_vpfc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);

### bench/vertex_position_format_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_position_format_converter_tb
// Self-checking bench for the vertex position format converter. A directed
// table covers format extremes, count and float corner cases, then random
// vertex positions run under several register settings with random stalls on
// both channels. Every result is checked against a behavioral converter.
// ----------------------------------------------------------------------------
module vertex_position_format_converter_tb;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam logic [2:0] FMT_F32 = 3'd4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  vpfc_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  vpfc_pkg::out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = vpfc_pkg::REG_SOURCE_FORMAT;
  logic [4:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  vertex_position_format_converter u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Local copy of the register file.
  logic [2:0] fmt_q = vpfc_pkg::FMT_U8;
  logic [1:0] count_q = vpfc_pkg::COUNT_THREE;
  logic [4:0] frac_q = '0;
  logic flt_q = 1'b0;

  vpfc_pkg::out_t pending_pos[$];
  int unsigned errors = 0;
  int unsigned n_req = 0;
  int unsigned n_rsp = 0;
  int unsigned idle_cycles = 0;
  bit rx_stall_en = 1'b1;

  // Directed rows: the expectation is typed in where check_row is set.
  typedef struct {
    logic [2:0] fmt;
    logic [1:0] cnt;
    logic [4:0] frac;
    logic flt;
    vpfc_pkg::in_t pos;
    bit check_row;
    vpfc_pkg::out_t want;
  } row_t;

  // Sign or zero extension per source format.
  function automatic int signed widen(logic [31:0] raw);
    case (fmt_q)
      vpfc_pkg::FMT_U8: return int'({24'd0, raw[7:0]});
      vpfc_pkg::FMT_S8: return int'({{24{raw[7]}}, raw[7:0]});
      vpfc_pkg::FMT_U16: return int'({16'd0, raw[15:0]});
      default: return int'({{16{raw[15]}}, raw[15:0]});
    endcase
  endfunction

  // Exact int to float32 and divide by 2^frac via exponent subtract. Inputs
  // are at most 16 bits of magnitude, so no rounding happens and results stay
  // normal (smallest is 1 * 2^-31).
  function automatic logic [31:0] scaled_float(int signed v);
    logic [31:0] mag;
    int msb;
    logic [31:0] frac_field;
    if (v == 0) return 32'd0;
    mag = (v < 0) ? -v : v;
    msb = 0;
    for (int i = 0; i < 32; i++) if (mag[i]) msb = i;
    frac_field = (mag << (23 - msb)) & 32'h007f_ffff;
    return {(v < 0), 8'(127 + msb - frac_q), frac_field[22:0]};
  endfunction

  function automatic logic [31:0] convert_comp(logic [31:0] raw, bit present);
    int signed v;
    if (fmt_q > vpfc_pkg::FMT_S16) return present ? raw : 32'd0;
    v = present ? widen(raw) : 0;
    return flt_q ? scaled_float(v) : 32'(v);
  endfunction

  function automatic vpfc_pkg::out_t convert_pos(vpfc_pkg::in_t p);
    vpfc_pkg::out_t r;
    bit native_int;
    native_int = (fmt_q <= vpfc_pkg::FMT_S16) && !flt_q;
    r.out_x = convert_comp(p.comp_x, 1'b1);
    r.out_y = convert_comp(p.comp_y, 1'b1);
    r.out_z = convert_comp(p.comp_z, count_q == vpfc_pkg::COUNT_THREE);
    r.scale_word = native_int ? 6'(frac_q) + 6'd1 : 6'd0;
    r.scale_valid = native_int;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      vpfc_pkg::REG_SOURCE_FORMAT: fmt_q = val[2:0];
      vpfc_pkg::REG_COMPONENT_COUNT: count_q = val[1:0];
      vpfc_pkg::REG_FRAC_BITS: frac_q = val;
      default: flt_q = val[0];
    endcase
  endtask

  // Stop sending, then wait out all outstanding results plus pipeline latency.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic [2:0] f, logic [1:0] c, logic [4:0] fr, logic fl);
    drain();
    write_reg(vpfc_pkg::REG_SOURCE_FORMAT, {2'd0, f});
    write_reg(vpfc_pkg::REG_COMPONENT_COUNT, {3'd0, c});
    write_reg(vpfc_pkg::REG_FRAC_BITS, fr);
    write_reg(vpfc_pkg::REG_FLOAT_OUTPUT, {4'd0, fl});
  endtask

  // Present one request; expectation is pushed when it is accepted. Valid
  // stays high afterwards so requests can follow back to back.
  task automatic send_pos(vpfc_pkg::in_t p, bit idle_en);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_pos.push_back(convert_pos(p));
    n_req++;
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Response side: random stall bursts, checks in order.
  always @(posedge clk_i) begin
    vpfc_pkg::out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) idle_cycles <= 0;
      else if (out_valid_o && out_ready_i) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && out_ready_i) begin
        n_rsp++;
        if (pending_pos.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_o);
          errors++;
        end else begin
          want = pending_pos.pop_front();
          if (out_data_o.out_x !== want.out_x)
            $display("%0t: out_x exp %h got %h", $time, want.out_x, out_data_o.out_x);
          if (out_data_o.out_y !== want.out_y)
            $display("%0t: out_y exp %h got %h", $time, want.out_y, out_data_o.out_y);
          if (out_data_o.out_z !== want.out_z)
            $display("%0t: out_z exp %h got %h", $time, want.out_z, out_data_o.out_z);
          if (out_data_o.scale_word !== want.scale_word)
            $display("%0t: scale_word exp %0d got %0d", $time, want.scale_word,
                     out_data_o.scale_word);
          if (out_data_o.scale_valid !== want.scale_valid)
            $display("%0t: scale_valid exp %b got %b", $time, want.scale_valid,
                     out_data_o.scale_valid);
          if (out_data_o !== want) errors++;
        end
      end
    end
  end

  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (!rx_stall_en) begin
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= (stall_left == 1);
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 8);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: stop if nothing moves for too long.
  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic row_t mk(logic [2:0] f, logic [1:0] c, logic [4:0] fr, logic fl,
                              logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              bit chk, vpfc_pkg::out_t w);
    row_t r;
    r.fmt = f; r.cnt = c; r.frac = fr; r.flt = fl;
    r.pos = '{comp_x: x, comp_y: y, comp_z: z};
    r.check_row = chk; r.want = w;
    return r;
  endfunction

  row_t dir_rows[$];
  vpfc_pkg::out_t got_pred;

  initial begin
    // Reset defaults: u8 native, three components, scale 1. High bits ignored.
    dir_rows.push_back(mk(vpfc_pkg::FMT_U8, vpfc_pkg::COUNT_THREE, 5'd0, 1'b0,
                          32'hffff_ff80, 32'h0, 32'h1ff,
                          1, '{32'h80, 32'h0, 32'hff, 6'd1, 1'b1}));
    dir_rows.push_back(mk(vpfc_pkg::FMT_S8, vpfc_pkg::COUNT_THREE, 5'd31, 1'b0,
                          32'h80, 32'h7f, 32'hff,
                          1, '{32'hffff_ff80, 32'h7f, 32'hffff_ffff, 6'd32, 1'b1}));
    dir_rows.push_back(mk(vpfc_pkg::FMT_U16, 2'd2, 5'd4, 1'b0, 32'hdead_ffff, 32'h0,
                          32'h1234, 1, '{32'hffff, 32'h0, 32'h0, 6'd5, 1'b1}));
    dir_rows.push_back(mk(vpfc_pkg::FMT_S16, 2'd0, 5'd0, 1'b0, 32'h8000, 32'h7fff, 32'h1,
                          1, '{32'hffff_8000, 32'h7fff, 32'h0, 6'd1, 1'b1}));
    dir_rows.push_back(mk(vpfc_pkg::FMT_S16, 2'd1, 5'd0, 1'b0, 32'h1, 32'h1, 32'h1,
                          1, '{32'h1, 32'h1, 32'h0, 6'd1, 1'b1}));
    // Float pass-through, NaN and undefined formats.
    dir_rows.push_back(mk(FMT_F32, vpfc_pkg::COUNT_THREE, 5'd7, 1'b0, 32'h7fc0_0001,
                          32'hffff_ffff, 32'h8000_0000,
                          1, '{32'h7fc0_0001, 32'hffff_ffff, 32'h8000_0000, 6'd0, 1'b0}));
    dir_rows.push_back(mk(3'd5, 2'd2, 5'd0, 1'b1, 32'h3f80_0000, 32'h1, 32'h5,
                          1, '{32'h3f80_0000, 32'h1, 32'h0, 6'd0, 1'b0}));
    dir_rows.push_back(mk(3'd7, vpfc_pkg::COUNT_THREE, 5'd0, 1'b0, 32'h0, 32'h1234_5678,
                          32'hffff_ffff,
                          1, '{32'h0, 32'h1234_5678, 32'hffff_ffff, 6'd0, 1'b0}));
    dir_rows.push_back(mk(3'd6, vpfc_pkg::COUNT_THREE, 5'd0, 1'b0, 32'h1, 32'h2, 32'h3,
                          0, '0));
    // Float mode: zero, one, -1, scaled extremes.
    dir_rows.push_back(mk(vpfc_pkg::FMT_S8, vpfc_pkg::COUNT_THREE, 5'd0, 1'b1, 32'h0,
                          32'h1, 32'hff,
                          1, '{32'h0, 32'h3f80_0000, 32'hbf80_0000, 6'd0, 1'b0}));
    dir_rows.push_back(mk(vpfc_pkg::FMT_S16, 2'd2, 5'd31, 1'b1, 32'h8000, 32'h7fff, 32'h1,
                          1, '{32'hb780_0000, 32'h377f_fe00, 32'h0, 6'd0, 1'b0}));
    dir_rows.push_back(mk(vpfc_pkg::FMT_U16, vpfc_pkg::COUNT_THREE, 5'd31, 1'b1, 32'hffff,
                          32'h1, 32'h0, 0, '0));
    dir_rows.push_back(mk(vpfc_pkg::FMT_U8, vpfc_pkg::COUNT_THREE, 5'd8, 1'b1, 32'hff,
                          32'h80, 32'h3, 0, '0));
    dir_rows.push_back(mk(vpfc_pkg::FMT_S8, 2'd2, 5'd3, 1'b1, 32'h81, 32'h7f, 32'hff,
                          0, '0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (i != 0) set_config(dir_rows[i].fmt, dir_rows[i].cnt, dir_rows[i].frac,
                             dir_rows[i].flt);
      got_pred = convert_pos(dir_rows[i].pos);
      if (dir_rows[i].check_row && got_pred !== dir_rows[i].want) begin
        $display("%0t: row %0d table exp %h predictor %h", $time, i, dir_rows[i].want,
                 got_pred);
        errors++;
      end
      if (dir_rows[i].check_row) begin
        send_pos(dir_rows[i].pos, 1'b0);
        void'(pending_pos.pop_back());
        pending_pos.push_back(dir_rows[i].want);
      end else begin
        send_pos(dir_rows[i].pos, 1'b0);
      end
    end

    // Random phases over varied settings, extremes included.
    for (int ph = 0; ph < 20; ph++) begin
      case (ph % 5)
        0: set_config(3'($urandom_range(0, 7)), 2'($urandom), 5'd0, 1'($urandom));
        1: set_config(3'($urandom_range(0, 3)), vpfc_pkg::COUNT_THREE, 5'd31,
                      1'($urandom));
        default: set_config(3'($urandom_range(0, 7)), 2'($urandom), 5'($urandom),
                            1'($urandom));
      endcase
      if (ph == 18) rx_stall_en = 1'b0;
      for (int k = 0; k < 25; k++) begin
        send_pos('{comp_x: rand_comp(), comp_y: rand_comp(), comp_z: rand_comp()},
                 ph < 18);
      end
      // Hold off the sender until everything is back once mid-run.
      if (ph == 10) begin
        in_valid_i <= 1'b0;
        while (pending_pos.size() != 0) @(posedge clk_i);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d vertex positions and checked %0d results", n_req, n_rsp);
    $display("over all source formats, component counts and scale settings.");
    if (errors == 0 && pending_pos.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
